// ----- rtl/svc_pkg.sv -----
// ----------------------------------------------------------------------------
// svc_pkg
// Shared types and constants for the solar valve controller.
// ----------------------------------------------------------------------------
`default_nettype none

package svc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned TEMP_WIDTH      = 8;
   localparam int unsigned HOLD_WIDTH      = 16;
   localparam int unsigned TIMER_WIDTH_DEF = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_CLOSE_MARGIN    = 3'd0,
      REG_OPEN_MARGIN     = 3'd1,
      REG_MIN_SUPPLY_TEMP = 3'd2,
      REG_CUTOFF_HYST     = 3'd3,
      REG_MOVE_HOLDOFF    = 3'd4,
      REG_STARTUP_DELAY   = 3'd5,
      REG_BAD_CODE        = 3'd6,
      REG_DEBUG_MODE      = 3'd7
   } csr_index_type;

   localparam logic [TEMP_WIDTH-1:0] CLOSE_MARGIN_RESET    = 8'd2;
   localparam logic [TEMP_WIDTH-1:0] OPEN_MARGIN_RESET     = 8'd2;
   localparam logic [TEMP_WIDTH-1:0] MIN_SUPPLY_TEMP_RESET = 8'd30;
   localparam logic [TEMP_WIDTH-1:0] CUTOFF_HYST_RESET     = 8'd5;
   localparam logic [HOLD_WIDTH-1:0] MOVE_HOLDOFF_RESET    = 16'd60;
   localparam logic [HOLD_WIDTH-1:0] STARTUP_DELAY_RESET   = 16'd10;
   localparam logic [TEMP_WIDTH-1:0] BAD_CODE_RESET        = 8'd255;
   localparam logic [TEMP_WIDTH-1:0] CUTOFF_RESET          = 8'd40;

   typedef struct packed {
      logic [TEMP_WIDTH-1:0] close_margin;
      logic [TEMP_WIDTH-1:0] open_margin;
      logic [TEMP_WIDTH-1:0] min_supply_temp;
      logic [TEMP_WIDTH-1:0] cutoff_hysteresis;
      logic [HOLD_WIDTH-1:0] move_holdoff;
      logic [HOLD_WIDTH-1:0] startup_delay;
      logic [TEMP_WIDTH-1:0] bad_code;
      logic                  debug_mode;
   } svc_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/svc_csr.sv -----
// ----------------------------------------------------------------------------
// svc_csr
// Configuration register file, write only, reset to the documented defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_csr
   import svc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output svc_cfg_type                     cfg
);

   svc_cfg_type cfg_ff;
   svc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_CLOSE_MARGIN:    cfg_in.close_margin      = csr_data[TEMP_WIDTH-1:0];
            REG_OPEN_MARGIN:     cfg_in.open_margin       = csr_data[TEMP_WIDTH-1:0];
            REG_MIN_SUPPLY_TEMP: cfg_in.min_supply_temp   = csr_data[TEMP_WIDTH-1:0];
            REG_CUTOFF_HYST:     cfg_in.cutoff_hysteresis = csr_data[TEMP_WIDTH-1:0];
            REG_MOVE_HOLDOFF:    cfg_in.move_holdoff      = csr_data[HOLD_WIDTH-1:0];
            REG_STARTUP_DELAY:   cfg_in.startup_delay     = csr_data[HOLD_WIDTH-1:0];
            REG_BAD_CODE:        cfg_in.bad_code          = csr_data[TEMP_WIDTH-1:0];
            REG_DEBUG_MODE:      cfg_in.debug_mode        = csr_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.close_margin      <= CLOSE_MARGIN_RESET;
         cfg_ff.open_margin       <= OPEN_MARGIN_RESET;
         cfg_ff.min_supply_temp   <= MIN_SUPPLY_TEMP_RESET;
         cfg_ff.cutoff_hysteresis <= CUTOFF_HYST_RESET;
         cfg_ff.move_holdoff      <= MOVE_HOLDOFF_RESET;
         cfg_ff.startup_delay     <= STARTUP_DELAY_RESET;
         cfg_ff.bad_code          <= BAD_CODE_RESET;
         cfg_ff.debug_mode        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- rtl/svc_core.sv -----
// ----------------------------------------------------------------------------
// svc_core
// Input register, valve decision logic with its state, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svc_core
   import svc_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire svc_cfg_type           cfg,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [TEMP_WIDTH-1:0] req_temp_supply,
   input  wire logic [TEMP_WIDTH-1:0] req_temp_inside,
   input  wire logic [TEMP_WIDTH-1:0] req_temp_top,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valve_state,
   output logic                       rsp_opened_now,
   output logic                       rsp_closed_now,
   output logic [TEMP_WIDTH-1:0]      rsp_cutoff_temp,
   output logic                       rsp_reading_bad,
   output logic                       rsp_holdoff_active
);

   localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

   // saturate a hold-off value into the timer
   function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [HOLD_WIDTH-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      return (v32 > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX) : TIMER_WIDTH'(v32);
   endfunction

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  kind_ff;
   logic [TEMP_WIDTH-1:0] sup_ff, ins_ff, top_ff;

   // block state
   logic                   valve_ff, valve_in;
   logic [TEMP_WIDTH-1:0]  cutoff_ff, cutoff_in;
   logic [TIMER_WIDTH-1:0] hold_ff, hold_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_valve_ff, out_opened_ff, out_closed_ff;
   logic [TEMP_WIDTH-1:0] out_cutoff_ff;
   logic                  out_bad_ff, out_hold_ff;

   logic out_ready, advance, accept;
   logic bad, flagged, opened, closed;
   logic [TEMP_WIDTH-1:0]  cutoff_raised;
   logic [TEMP_WIDTH:0]    sup_close, top_open, cutoff_hyst;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   // widened sums so the compares never wrap
   assign sup_close   = {1'b0, sup_ff} + {1'b0, cfg.close_margin};
   assign top_open    = {1'b0, top_ff} + {1'b0, cfg.open_margin};
   assign cutoff_hyst = {1'b0, cutoff_ff} + {1'b0, cfg.cutoff_hysteresis};

   always_comb begin
      bad = (sup_ff == cfg.bad_code) || (ins_ff == cfg.bad_code) ||
            (top_ff == cfg.bad_code);
      flagged       = 1'b0;
      opened        = 1'b0;
      closed        = 1'b0;
      valve_in      = valve_ff;
      cutoff_in     = cutoff_ff;
      hold_in       = hold_ff;
      cutoff_raised = cutoff_ff;
      if (!kind_ff) begin
         if (hold_ff != '0) begin
            hold_in = hold_ff - TIMER_WIDTH'(1);
         end
      end else if (bad && !cfg.debug_mode) begin
         flagged = 1'b1;
         hold_in = timer_load(cfg.startup_delay);
      end else begin
         if (valve_ff && ({1'b0, top_ff} > cutoff_hyst)) begin
            cutoff_raised = top_ff - cfg.cutoff_hysteresis;
         end
         cutoff_in = cutoff_raised;
         if ((hold_ff == '0) && !bad) begin
            if (valve_ff) begin
               if (({1'b0, top_ff} >= sup_close) || ({1'b0, ins_ff} > sup_close) ||
                   (sup_ff < cutoff_raised) || (sup_ff < cfg.min_supply_temp)) begin
                  valve_in = 1'b0;
                  closed   = 1'b1;
                  hold_in  = timer_load(cfg.move_holdoff);
               end
            end else if (({1'b0, sup_ff} >= top_open) &&
                         (sup_ff >= cfg.min_supply_temp)) begin
               valve_in  = 1'b1;
               opened    = 1'b1;
               cutoff_in = top_ff;
               hold_in   = timer_load(cfg.move_holdoff);
            end
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valve_ff     <= 1'b1;
         cutoff_ff    <= CUTOFF_RESET;
         hold_ff      <= timer_load(STARTUP_DELAY_RESET);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            valve_ff  <= valve_in;
            cutoff_ff <= cutoff_in;
            hold_ff   <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_kind;
         sup_ff  <= req_temp_supply;
         ins_ff  <= req_temp_inside;
         top_ff  <= req_temp_top;
      end
      if (advance) begin
         out_valve_ff  <= valve_in;
         out_opened_ff <= opened;
         out_closed_ff <= closed;
         out_cutoff_ff <= cutoff_in;
         out_bad_ff    <= flagged;
         out_hold_ff   <= (hold_in != '0);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_valve_state    = out_valve_ff;
   assign rsp_opened_now     = out_opened_ff;
   assign rsp_closed_now     = out_closed_ff;
   assign rsp_cutoff_temp    = out_cutoff_ff;
   assign rsp_reading_bad    = out_bad_ff;
   assign rsp_holdoff_active = out_hold_ff;

endmodule

`default_nettype wire

// ----- rtl/solar_valve_controller_unit.sv -----
// ----------------------------------------------------------------------------
// solar_valve_controller_unit
// Solar hot-water valve controller: ticks and temperature sets in, valve
// state and status out, one result item per input item.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: a time tick (req_kind 0) or a measurement set of
//   supply, inside and tank-top temperatures (req_kind 1). An item is taken
//   when req_valid is high and req_stall is low. rsp_* returns one result
//   item per input item, taken when rsp_valid is high and rsp_stall is low.
//   The item is captured in an input register; the decision and state
//   update happen as it moves into the result register.
//   Throughput is one item per cycle; req_stall rises only when both the
//   input and the result register hold items and the receiver stalls.
//   csr_* writes one configuration register per cycle when csr_write_en is
//   high; write only while no item is in flight.
//   Synchronous reset empties both registers, sets the valve open, the
//   cutoff to 40 and the hold-off to the startup delay default; all
//   configuration registers return to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module solar_valve_controller_unit
   import svc_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_kind,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_supply,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_inside,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_top,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_valve_state,
   output logic                            rsp_opened_now,
   output logic                            rsp_closed_now,
   output logic [TEMP_WIDTH-1:0]           rsp_cutoff_temp,
   output logic                            rsp_reading_bad,
   output logic                            rsp_holdoff_active
);

   svc_cfg_type cfg;

   svc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   svc_core #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_temp_supply    (req_temp_supply),
      .req_temp_inside    (req_temp_inside),
      .req_temp_top       (req_temp_top),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_valve_state    (rsp_valve_state),
      .rsp_opened_now     (rsp_opened_now),
      .rsp_closed_now     (rsp_closed_now),
      .rsp_cutoff_temp    (rsp_cutoff_temp),
      .rsp_reading_bad    (rsp_reading_bad),
      .rsp_holdoff_active (rsp_holdoff_active)
   );

endmodule

`default_nettype wire

// ----- tb/sv/svc_valve_checker.sv -----
// ----------------------------------------------------------------------------
// svc_valve_checker
// Watches the csr, req and rsp ports of the solar valve controller. Keeps its
// own copy of the configuration and valve state, predicts one status item per
// accepted input item and compares it field by field with the rsp stream.
// ----------------------------------------------------------------------------
module svc_valve_checker
   import svc_pkg::*;
#(
   parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic                       req_kind,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_supply,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_inside,
   input  wire logic [TEMP_WIDTH-1:0]      req_temp_top,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic                       rsp_valve_state,
   input  wire logic                       rsp_opened_now,
   input  wire logic                       rsp_closed_now,
   input  wire logic [TEMP_WIDTH-1:0]      rsp_cutoff_temp,
   input  wire logic                       rsp_reading_bad,
   input  wire logic                       rsp_holdoff_active,
   output int unsigned                     error_count,
   output int unsigned                     checked_count
);

   typedef struct packed {
      logic                  valve_state;
      logic                  opened_now;
      logic                  closed_now;
      logic [TEMP_WIDTH-1:0] cutoff_temp;
      logic                  reading_bad;
      logic                  holdoff_active;
   } valve_status_type;

   svc_cfg_type           cfg;
   logic                  valve_is_open;
   logic [TEMP_WIDTH-1:0] cutoff;
   longint unsigned       holdoff_left;
   valve_status_type      status_queue[$];

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      if (error_count < 50) begin
         $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
      end
      error_count++;
   endtask

   // loads saturate at what the timer can hold
   function automatic longint unsigned timer_load(input logic [HOLD_WIDTH-1:0] ticks);
      longint unsigned ceiling;
      ceiling = (64'd1 << TIMER_WIDTH) - 1;
      return (ticks > ceiling) ? ceiling : longint'(ticks);
   endfunction

   function automatic valve_status_type next_valve_status(input logic kind,
         input logic [TEMP_WIDTH-1:0] sup, input logic [TEMP_WIDTH-1:0] ins,
         input logic [TEMP_WIDTH-1:0] top);
      valve_status_type st;
      logic             bad;
      int unsigned      s, i, t, cm, om, hy, cut;
      st  = '0;
      s   = sup;
      i   = ins;
      t   = top;
      cm  = cfg.close_margin;
      om  = cfg.open_margin;
      hy  = cfg.cutoff_hysteresis;
      bad = (sup == cfg.bad_code) || (ins == cfg.bad_code) || (top == cfg.bad_code);
      if (!kind) begin
         if (holdoff_left != 0) holdoff_left--;
      end else if (bad && !cfg.debug_mode) begin
         st.reading_bad = 1'b1;
         holdoff_left   = timer_load(cfg.startup_delay);
      end else begin
         cut = cutoff;
         if (valve_is_open && t > cut + hy) begin
            cutoff = top - cfg.cutoff_hysteresis;
         end
         cut = cutoff;
         if (holdoff_left == 0 && !bad) begin
            if (valve_is_open) begin
               if (t >= s + cm || i > s + cm || s < cut || sup < cfg.min_supply_temp) begin
                  valve_is_open = 1'b0;
                  st.closed_now = 1'b1;
                  holdoff_left  = timer_load(cfg.move_holdoff);
               end
            end else if (s >= t + om && sup >= cfg.min_supply_temp) begin
               valve_is_open = 1'b1;
               st.opened_now = 1'b1;
               cutoff        = top;
               holdoff_left  = timer_load(cfg.move_holdoff);
            end
         end
      end
      st.valve_state    = valve_is_open;
      st.cutoff_temp    = cutoff;
      st.holdoff_active = (holdoff_left != 0);
      return st;
   endfunction

   always @(posedge clock) begin
      valve_status_type got;
      valve_status_type want;
      if (reset) begin
         cfg.close_margin      = CLOSE_MARGIN_RESET;
         cfg.open_margin       = OPEN_MARGIN_RESET;
         cfg.min_supply_temp   = MIN_SUPPLY_TEMP_RESET;
         cfg.cutoff_hysteresis = CUTOFF_HYST_RESET;
         cfg.move_holdoff      = MOVE_HOLDOFF_RESET;
         cfg.startup_delay     = STARTUP_DELAY_RESET;
         cfg.bad_code          = BAD_CODE_RESET;
         cfg.debug_mode        = 1'b0;
         valve_is_open         = 1'b1;
         cutoff                = CUTOFF_RESET;
         holdoff_left          = timer_load(STARTUP_DELAY_RESET);
         error_count           = 0;
         checked_count         = 0;
         status_queue.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_CLOSE_MARGIN:    cfg.close_margin      = csr_data[TEMP_WIDTH-1:0];
               REG_OPEN_MARGIN:     cfg.open_margin       = csr_data[TEMP_WIDTH-1:0];
               REG_MIN_SUPPLY_TEMP: cfg.min_supply_temp   = csr_data[TEMP_WIDTH-1:0];
               REG_CUTOFF_HYST:     cfg.cutoff_hysteresis = csr_data[TEMP_WIDTH-1:0];
               REG_MOVE_HOLDOFF:    cfg.move_holdoff      = csr_data[HOLD_WIDTH-1:0];
               REG_STARTUP_DELAY:   cfg.startup_delay     = csr_data[HOLD_WIDTH-1:0];
               REG_BAD_CODE:        cfg.bad_code          = csr_data[TEMP_WIDTH-1:0];
               REG_DEBUG_MODE:      cfg.debug_mode        = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_valve_state, rsp_opened_now, rsp_closed_now, rsp_cutoff_temp,
                   rsp_reading_bad, rsp_holdoff_active};
            if (status_queue.size() == 0) begin
               report_mismatch("result item with nothing outstanding", got, 0);
            end else begin
               want = status_queue.pop_front();
               checked_count++;
               if (got.valve_state !== want.valve_state)
                  report_mismatch("valve_state", got.valve_state, want.valve_state);
               if (got.opened_now !== want.opened_now)
                  report_mismatch("opened_now", got.opened_now, want.opened_now);
               if (got.closed_now !== want.closed_now)
                  report_mismatch("closed_now", got.closed_now, want.closed_now);
               if (got.cutoff_temp !== want.cutoff_temp)
                  report_mismatch("cutoff_temp", got.cutoff_temp, want.cutoff_temp);
               if (got.reading_bad !== want.reading_bad)
                  report_mismatch("reading_bad", got.reading_bad, want.reading_bad);
               if (got.holdoff_active !== want.holdoff_active)
                  report_mismatch("holdoff_active", got.holdoff_active, want.holdoff_active);
            end
         end
         if (req_valid && !req_stall) begin
            status_queue.push_back(next_valve_status(req_kind, req_temp_supply,
                                                     req_temp_inside, req_temp_top));
         end
      end
   end

endmodule

// ----- tb/sv/tb_solar_valve_controller_unit.sv -----
// ----------------------------------------------------------------------------
// tb_solar_valve_controller_unit
// Drives ticks and temperature sets into the valve controller under several
// register settings, with random gaps and receiver stalls; the checker beside
// the block predicts and compares every status item.
// ----------------------------------------------------------------------------
module tb_solar_valve_controller_unit
   import svc_pkg::*;
();

   localparam int unsigned RUN_LIMIT    = 200000;
   localparam int unsigned RANDOM_ITEMS = 650;
   localparam int unsigned PHASE_COUNT  = 8;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       csr_write_en    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index       = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data        = '0;
   logic                       req_valid       = 1'b0;
   logic                       req_kind        = 1'b0;
   logic [TEMP_WIDTH-1:0]      req_temp_supply = '0;
   logic [TEMP_WIDTH-1:0]      req_temp_inside = '0;
   logic [TEMP_WIDTH-1:0]      req_temp_top    = '0;
   logic                       rsp_stall       = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic                       rsp_valve_state;
   logic                       rsp_opened_now;
   logic                       rsp_closed_now;
   logic [TEMP_WIDTH-1:0]      rsp_cutoff_temp;
   logic                       rsp_reading_bad;
   logic                       rsp_holdoff_active;
   int unsigned                error_count;
   int unsigned                checked_count;

   // no idle cycles on either side while set
   logic                       calm            = 1'b0;
   svc_cfg_type                cfg_now;
   int unsigned                items_sent      = 0;
   int unsigned                settings_loaded = 0;
   int unsigned                cycle_count     = 0;

   solar_valve_controller_unit DUT (.*);

   svc_valve_checker #(.TIMER_WIDTH(TIMER_WIDTH_DEF)) u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_solar_valve_controller_unit: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 18);
   end

   task automatic send_item(input logic kind, input logic [TEMP_WIDTH-1:0] sup,
                            input logic [TEMP_WIDTH-1:0] ins,
                            input logic [TEMP_WIDTH-1:0] top);
      if (!calm) begin
         while ($urandom_range(0, 99) < 18) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_temp_supply <= sup;
      req_temp_inside <= ins;
      req_temp_top    <= top;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // block is empty once every item has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (checked_count != items_sent) @(posedge clock);
   endtask

   task automatic load_settings(input svc_cfg_type c);
      csr_index_type r;
      r = r.first();
      csr_write_en <= 1'b1;
      do begin
         csr_index <= r;
         case (r)
            REG_CLOSE_MARGIN:    csr_data <= CSR_DATA_WIDTH'(c.close_margin);
            REG_OPEN_MARGIN:     csr_data <= CSR_DATA_WIDTH'(c.open_margin);
            REG_MIN_SUPPLY_TEMP: csr_data <= CSR_DATA_WIDTH'(c.min_supply_temp);
            REG_CUTOFF_HYST:     csr_data <= CSR_DATA_WIDTH'(c.cutoff_hysteresis);
            REG_MOVE_HOLDOFF:    csr_data <= c.move_holdoff;
            REG_STARTUP_DELAY:   csr_data <= c.startup_delay;
            REG_BAD_CODE:        csr_data <= CSR_DATA_WIDTH'(c.bad_code);
            REG_DEBUG_MODE:      csr_data <= CSR_DATA_WIDTH'(c.debug_mode);
            default:             csr_data <= '0;
         endcase
         @(posedge clock);
         r = r.next();
      end while (r != r.first());
      csr_write_en <= 1'b0;
      cfg_now = c;
      settings_loaded++;
   endtask

   // mostly plausible readings close to each other, some bad codes and noise
   task automatic random_item();
      int unsigned           pick;
      logic                  kind;
      logic [TEMP_WIDTH-1:0] sup;
      logic [TEMP_WIDTH-1:0] ins;
      logic [TEMP_WIDTH-1:0] top;
      pick = $urandom_range(0, 99);
      kind = (pick >= 40);
      top  = TEMP_WIDTH'($urandom_range(0, 110));
      sup  = top + TEMP_WIDTH'($urandom_range(0, 16)) - 8'd8;
      ins  = sup + TEMP_WIDTH'($urandom_range(0, 12)) - 8'd6;
      if (pick < 40 || pick >= 94) begin
         {sup, ins, top} = 24'($urandom);
         if (pick >= 94) kind = 1'($urandom);
      end else if (pick >= 88) begin
         case ($urandom_range(0, 2))
            0:       sup = cfg_now.bad_code;
            1:       ins = cfg_now.bad_code;
            default: top = cfg_now.bad_code;
         endcase
      end
      send_item(kind, sup, ins, top);
   endtask

   initial begin
      svc_cfg_type c;
      cfg_now = '{CLOSE_MARGIN_RESET, OPEN_MARGIN_RESET, MIN_SUPPLY_TEMP_RESET,
                  CUTOFF_HYST_RESET, MOVE_HOLDOFF_RESET, STARTUP_DELAY_RESET,
                  BAD_CODE_RESET, 1'b0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: cutoff raise, bad code on each field, startup hold-off
      send_item(1'b1, 8'd50, 8'd40, 8'd60);
      send_item(1'b1, 8'd255, 8'd0, 8'd0);
      send_item(1'b1, 8'd0, 8'd255, 8'd0);
      send_item(1'b1, 8'd0, 8'd0, 8'd255);
      for (int k = 0; k < 11; k++) begin
         send_item(1'b0, (k % 2) ? 8'hFF : 8'h00, (k % 2) ? 8'hFF : 8'h00,
                   (k % 2) ? 8'hFF : 8'h00);
      end
      send_item(1'b1, 8'd80, 8'd20, 8'd20);
      send_item(1'b1, 8'd40, 8'd100, 8'd50);

      // bad code zero with debug on, hold-off settings zero, close margin and hysteresis widest, open margin zero
      drain();
      load_settings('{8'd255, 8'd0, 8'd0, 8'd255, 16'd0, 16'd0, 8'd0, 1'b1});
      send_item(1'b1, 8'd0, 8'd0, 8'd0);
      send_item(1'b1, 8'd10, 8'd5, 8'd10);
      send_item(1'b1, 8'd255, 8'd255, 8'd255);
      send_item(1'b1, 8'd0, 8'd50, 8'd255);
      send_item(1'b0, 8'd0, 8'd0, 8'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         c.close_margin      = TEMP_WIDTH'($urandom_range(0, 6));
         c.open_margin       = TEMP_WIDTH'($urandom_range(0, 6));
         c.min_supply_temp   = TEMP_WIDTH'($urandom_range(0, 60));
         c.cutoff_hysteresis = TEMP_WIDTH'($urandom_range(0, 10));
         c.move_holdoff      = HOLD_WIDTH'($urandom_range(0, 4));
         c.startup_delay     = HOLD_WIDTH'($urandom_range(0, 4));
         c.bad_code          = ($urandom_range(0, 1)) ? 8'd255 : TEMP_WIDTH'($urandom);
         c.debug_mode        = 1'($urandom);
         if (phase == 0) begin
            c = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1};
         end else if (phase == 1) begin
            c = '0;
         end else if (phase == 2) begin
            c = '{CLOSE_MARGIN_RESET, OPEN_MARGIN_RESET, MIN_SUPPLY_TEMP_RESET,
                  CUTOFF_HYST_RESET, 16'd8, STARTUP_DELAY_RESET, BAD_CODE_RESET, 1'b0};
         end
         drain();
         calm = (phase == 4);
         load_settings(c);
         repeat (RANDOM_ITEMS / PHASE_COUNT) random_item();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("summary: %0d items under %0d register settings, %0d status items compared",
               items_sent, settings_loaded, checked_count);
      $display("summary: ticks, measurements, bad readings with debug on and off, gaps and stalls");
      if (error_count == 0) begin
         $display("tb_solar_valve_controller_unit: clean");
      end else begin
         $display("tb_solar_valve_controller_unit: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/svc_pkg.sv
rtl/svc_csr.sv
rtl/svc_core.sv
rtl/solar_valve_controller_unit.sv
tb/sv/svc_valve_checker.sv
tb/sv/tb_solar_valve_controller_unit.sv
